[src/cpc_pkg.sv]
`default_nettype none

package cpc_pkg;

   localparam int STATUS_BITS = 2;
   localparam int TRIPLES     = 3;

   localparam logic [STATUS_BITS-1:0] STATUS_CONVEX  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_CONCAVE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SHORT   = 2'd2;

   // control that rides along with one vertex through the pipe
   typedef struct packed {
      logic                 last;
      logic                 short_poly;
      logic [TRIPLES-1:0]   use_triple;
   } tag_type;

endpackage

`default_nettype wire

[src/cpc_if.sv]
`default_nettype none

interface cpc_req_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface cpc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

[src/convex_polygon_check.sv]
// Path: the last vertex passes the difference, product and status registers, in that order.
// Throughput: one vertex beat per cycle while no status beat is held; the two wrap-around
// cross products of the last vertex run beside the regular one, so it needs no extra pass.
// Stages: difference register, product register (six multipliers), status register.
// Stalls: a held status beat stops the next last vertex and every vertex behind it.
// Reset: synchronous, active high; clears vertex count, turn state and all valid flags.
`default_nettype none

module convex_polygon_check #(
   parameter int COORD_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cpc_req_if.sink    req_chan,
   cpc_rsp_if.source  rsp_chan
);
   import cpc_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic                 a_valid, b_ready, a_take;
   tag_type              a_tag;
   logic signed [DW-1:0] a_dx1 [TRIPLES];
   logic signed [DW-1:0] a_dy1 [TRIPLES];
   logic signed [DW-1:0] a_dx2 [TRIPLES];
   logic signed [DW-1:0] a_dy2 [TRIPLES];
   logic signed [PW-1:0] p_prod [TRIPLES];
   logic signed [PW-1:0] q_prod [TRIPLES];

   assign a_take = a_valid && b_ready;

   cpc_front #(
      .COORD_BITS (COORD_BITS),
      .DW         (DW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .a_take   (a_take),
      .a_valid  (a_valid),
      .a_tag    (a_tag),
      .a_dx1    (a_dx1),
      .a_dy1    (a_dy1),
      .a_dx2    (a_dx2),
      .a_dy2    (a_dy2)
   );

   for (genvar i = 0; i < TRIPLES; i++) begin : g_cross
      cpc_cross #(
         .DW (DW),
         .PW (PW)
      ) u_cross (
         .clock  (clock),
         .load   (a_take),
         .dx1    (a_dx1[i]),
         .dy1    (a_dy1[i]),
         .dx2    (a_dx2[i]),
         .dy2    (a_dy2[i]),
         .p_prod (p_prod[i]),
         .q_prod (q_prod[i])
      );
   end

   cpc_judge #(
      .PW (PW)
   ) u_judge (
      .clock    (clock),
      .reset    (reset),
      .a_valid  (a_valid),
      .a_tag    (a_tag),
      .b_ready  (b_ready),
      .p_prod   (p_prod),
      .q_prod   (q_prod),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[src/cpc_front.sv]
`default_nettype none

module cpc_front #(
   parameter int COORD_BITS = 16,
   parameter int DW         = COORD_BITS + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cpc_req_if.sink                req_chan,
   input  wire logic              a_take,
   output logic                   a_valid,
   output cpc_pkg::tag_type       a_tag,
   output logic signed [DW-1:0]   a_dx1 [cpc_pkg::TRIPLES],
   output logic signed [DW-1:0]   a_dy1 [cpc_pkg::TRIPLES],
   output logic signed [DW-1:0]   a_dx2 [cpc_pkg::TRIPLES],
   output logic signed [DW-1:0]   a_dy2 [cpc_pkg::TRIPLES]
);
   import cpc_pkg::*;

   localparam logic [1:0] COUNT_MAX = 2'd3;

   logic                         accept;
   logic [1:0]                   count_ff, count_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic signed [COORD_BITS-1:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic signed [COORD_BITS-1:0] vx, vy;
   logic                         valid_ff;
   tag_type                      tag_ff, tag_in;
   logic signed [DW-1:0]         dx1_ff [TRIPLES];
   logic signed [DW-1:0]         dy1_ff [TRIPLES];
   logic signed [DW-1:0]         dx2_ff [TRIPLES];
   logic signed [DW-1:0]         dy2_ff [TRIPLES];
   logic                         have_two;

   function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] b,
                                                 input logic signed [COORD_BITS-1:0] a);
      diff = DW'(b) - DW'(a);
   endfunction

   assign vx       = req_chan.vertex_x;
   assign vy       = req_chan.vertex_y;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !valid_ff || a_take;
   assign have_two = count_ff[1];
   assign count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 2'd1;

   always_comb begin
      tag_in.last          = req_chan.last_vertex;
      tag_in.short_poly    = !have_two;
      tag_in.use_triple[0] = have_two;
      tag_in.use_triple[1] = have_two && req_chan.last_vertex;
      tag_in.use_triple[2] = have_two && req_chan.last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= req_chan.last_vertex ? 2'd0 : count_in;
            valid_ff <= 1'b1;
         end else if (a_take) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == 2'd0) begin
            first_x_ff <= vx;
            first_y_ff <= vy;
         end
         if (count_ff == 2'd1) begin
            second_x_ff <= vx;
            second_y_ff <= vy;
         end
         older_x_ff <= newer_x_ff;
         older_y_ff <= newer_y_ff;
         newer_x_ff <= vx;
         newer_y_ff <= vy;
         tag_ff     <= tag_in;
         // triple (older, newer, v)
         dx1_ff[0]  <= diff(newer_x_ff, older_x_ff);
         dy1_ff[0]  <= diff(newer_y_ff, older_y_ff);
         dx2_ff[0]  <= diff(vx, older_x_ff);
         dy2_ff[0]  <= diff(vy, older_y_ff);
         // wrap triple (newer, v, first)
         dx1_ff[1]  <= diff(vx, newer_x_ff);
         dy1_ff[1]  <= diff(vy, newer_y_ff);
         dx2_ff[1]  <= diff(first_x_ff, newer_x_ff);
         dy2_ff[1]  <= diff(first_y_ff, newer_y_ff);
         // wrap triple (v, first, second)
         dx1_ff[2]  <= diff(first_x_ff, vx);
         dy1_ff[2]  <= diff(first_y_ff, vy);
         dx2_ff[2]  <= diff(second_x_ff, vx);
         dy2_ff[2]  <= diff(second_y_ff, vy);
      end
   end

   assign a_valid = valid_ff;
   assign a_tag   = tag_ff;
   assign a_dx1   = dx1_ff;
   assign a_dy1   = dy1_ff;
   assign a_dx2   = dx2_ff;
   assign a_dy2   = dy2_ff;

endmodule

`default_nettype wire

[src/cpc_cross.sv]
`default_nettype none

module cpc_cross #(
   parameter int DW = 17,
   parameter int PW = 2 * DW
) (
   input  wire logic                    clock,
   input  wire logic                    load,
   input  wire logic signed [DW-1:0]    dx1,
   input  wire logic signed [DW-1:0]    dy1,
   input  wire logic signed [DW-1:0]    dx2,
   input  wire logic signed [DW-1:0]    dy2,
   output logic signed [PW-1:0]         p_prod,
   output logic signed [PW-1:0]         q_prod
);

   logic signed [PW-1:0] p_ff, q_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         p_ff <= PW'(dx1) * PW'(dy2);
         q_ff <= PW'(dy1) * PW'(dx2);
      end
   end

   assign p_prod = p_ff;
   assign q_prod = q_ff;

endmodule

`default_nettype wire

[src/cpc_judge.sv]
`default_nettype none

module cpc_judge #(
   parameter int PW = 34
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              a_valid,
   input  wire cpc_pkg::tag_type  a_tag,
   output logic                   b_ready,
   input  wire logic signed [PW-1:0] p_prod [cpc_pkg::TRIPLES],
   input  wire logic signed [PW-1:0] q_prod [cpc_pkg::TRIPLES],
   cpc_rsp_if.source              rsp_chan
);
   import cpc_pkg::*;

   typedef enum logic [1:0] {
      TURN_NONE,
      TURN_POS,
      TURN_NEG
   } turn_type;

   logic                   b_valid_ff;
   tag_type                b_tag_ff;
   logic                   b_go, out_free, a_take;
   turn_type               turn_ff, turn_in;
   logic                   broken_ff, broken_in;
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] status_ff;
   turn_type               sgn [TRIPLES];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign b_go     = b_valid_ff && (!b_tag_ff.last || out_free);
   assign b_ready  = !b_valid_ff || b_go;
   assign a_take   = a_valid && b_ready;

   always_comb begin
      turn_in   = turn_ff;
      broken_in = broken_ff;
      for (int i = 0; i < TRIPLES; i++) begin
         if (p_prod[i] > q_prod[i]) begin
            sgn[i] = TURN_POS;
         end else if (p_prod[i] < q_prod[i]) begin
            sgn[i] = TURN_NEG;
         end else begin
            sgn[i] = TURN_NONE;
         end
         if (b_tag_ff.use_triple[i] && sgn[i] != TURN_NONE) begin
            if (turn_in == TURN_NONE) begin
               turn_in = sgn[i];
            end else if (turn_in != sgn[i]) begin
               broken_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         turn_ff      <= TURN_NONE;
         broken_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_take) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go && b_tag_ff.last) begin
            rsp_valid_ff <= 1'b1;
            turn_ff      <= TURN_NONE;
            broken_ff    <= 1'b0;
         end else begin
            if (rsp_chan.ready) begin
               rsp_valid_ff <= 1'b0;
            end
            if (b_go) begin
               turn_ff   <= turn_in;
               broken_ff <= broken_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         b_tag_ff <= a_tag;
      end
      if (b_go && b_tag_ff.last) begin
         if (b_tag_ff.short_poly) begin
            status_ff <= STATUS_SHORT;
         end else if (broken_in) begin
            status_ff <= STATUS_CONCAVE;
         end else begin
            status_ff <= STATUS_CONVEX;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

endmodule

`default_nettype wire

[tb/cpc_checker.sv]
`timescale 1ns / 1ps

module cpc_checker (
   input  logic clock,
   input  logic reset,
   cpc_req_if   req_chan,
   cpc_rsp_if   rsp_chan,
   output int   fail_count,
   output int   outstanding
);
   import cpc_pkg::*;

   typedef enum logic [1:0] {
      TURN_NONE  = 2'd0,
      TURN_LEFT  = 2'd1,
      TURN_RIGHT = 2'd2
   } turn_type;

   typedef struct {
      longint x;
      longint y;
   } point_type;

   point_type first_pt;
   point_type second_pt;
   point_type older_pt;
   point_type newer_pt;
   int        seen;
   turn_type  heading;
   bit        bent;

   logic [STATUS_BITS-1:0] expected_status[$];
   int errors = 0;

   assign fail_count = errors;

   task automatic report(input string what);
      $display("%0t ns: %s", $realtime, what);
      errors++;
   endtask

   function automatic turn_type turn_of(point_type a, point_type b, point_type c);
      longint det;
      det = (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
      if (det > 0) return TURN_LEFT;
      if (det < 0) return TURN_RIGHT;
      return TURN_NONE;
   endfunction

   function automatic void note_turn(point_type a, point_type b, point_type c);
      turn_type t;
      t = turn_of(a, b, c);
      if (t == TURN_NONE) return;
      if (heading == TURN_NONE) heading = t;
      else if (heading != t) bent = 1'b1;
   endfunction

   function automatic void clear_outline();
      first_pt  = '{0, 0};
      second_pt = '{0, 0};
      older_pt  = '{0, 0};
      newer_pt  = '{0, 0};
      seen      = 0;
      heading   = TURN_NONE;
      bent      = 1'b0;
   endfunction

   function automatic void absorb_vertex(longint x, longint y, logic last);
      point_type v;
      v = '{x, y};
      if (seen == 0) first_pt = v;
      else if (seen == 1) second_pt = v;
      else note_turn(older_pt, newer_pt, v);
      older_pt = newer_pt;
      newer_pt = v;
      if (seen < 3) seen++;
      if (!last) return;
      if (seen < 3) begin
         expected_status.push_back(STATUS_SHORT);
      end else begin
         note_turn(older_pt, newer_pt, first_pt);
         note_turn(newer_pt, first_pt, second_pt);
         expected_status.push_back(bent ? STATUS_CONCAVE : STATUS_CONVEX);
      end
      clear_outline();
   endfunction

   initial clear_outline();

   always @(posedge clock) begin
      if (reset) begin
         clear_outline();
         expected_status.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_status.size() == 0) begin
               report($sformatf("status beat %0d with nothing expected", rsp_chan.status));
            end else begin
               if (rsp_chan.status !== expected_status[0])
                  report($sformatf("status %0d, expected %0d",
                                   rsp_chan.status, expected_status[0]));
               void'(expected_status.pop_front());
            end
         end
         if (req_chan.valid && req_chan.ready)
            absorb_vertex(longint'($signed(req_chan.vertex_x)),
                          longint'($signed(req_chan.vertex_y)), req_chan.last_vertex);
      end
      outstanding <= expected_status.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_BITS = 16;
   localparam int RANDOM_BEATS = 1450;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;

   cpc_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   cpc_rsp_if rsp_chan ();

   convex_polygon_check #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cpc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   // result side: stall pattern changes every stretch
   initial begin : receiver
      int mode;
      int stretch;
      int tick;
      rsp_chan.ready = 1'b0;
      mode = 0;
      stretch = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
         end
         stretch--;
         tick++;
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= (tick % 3 == 0);
         endcase
      end
   end

   int beats_sent = 0;
   int burst_left = 0;
   int ring_x[$];
   int ring_y[$];

   task automatic send_beat(input int x, input int y, input logic last);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= x[COORD_BITS-1:0];
      req_chan.vertex_y    <= y[COORD_BITS-1:0];
      req_chan.last_vertex <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_ring();
      for (int i = 0; i < ring_x.size(); i++)
         send_beat(ring_x[i], ring_y[i], i == ring_x.size() - 1);
      ring_x.delete();
      ring_y.delete();
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic add_vertex(input int x, input int y);
      ring_x.push_back(x);
      ring_y.push_back(y);
   endtask

   function automatic int rand_coord();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
      return int'($signed(16'($urandom)));
   endfunction

   // vertices on an ellipse in angular order, either winding
   task automatic make_convex(input int n);
      real cx, cy, rx, ry, total, acc, dir;
      real w[];
      w = new[n];
      cx = real'($urandom_range(0, 32000)) - 16000.0;
      cy = real'($urandom_range(0, 32000)) - 16000.0;
      if ($urandom_range(0, 3) == 0) begin
         rx = real'($urandom_range(1, 60));
         ry = real'($urandom_range(1, 60));
      end else begin
         rx = real'($urandom_range(1, 16000));
         ry = real'($urandom_range(1, 16000));
      end
      total = 0.0;
      for (int i = 0; i < n; i++) begin
         w[i] = real'($urandom_range(1, 1000));
         total += w[i];
      end
      dir = $urandom_range(0, 1) ? 1.0 : -1.0;
      acc = real'($urandom_range(0, 6283)) / 1000.0;
      for (int i = 0; i < n; i++) begin
         add_vertex($rtoi(cx + rx * $cos(acc)), $rtoi(cy + ry * $sin(acc)));
         acc += dir * 6.2831853 * w[i] / total;
      end
   endtask

   task automatic make_collinear(input int n);
      int bx, by, dx, dy, k;
      bx = $urandom_range(0, 20000) - 10000;
      by = $urandom_range(0, 20000) - 10000;
      dx = $urandom_range(0, 80) - 40;
      dy = $urandom_range(0, 80) - 40;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 1000) - 500;
         add_vertex(bx + k * dx, by + k * dy);
      end
      if ($urandom_range(0, 2) == 0) begin
         k = $urandom_range(0, n - 1);
         ring_x[k] = ring_x[k] + ($urandom_range(0, 1) ? 1 : -1);
      end
   endtask

   initial begin : stimulus
      int pick;
      int n;
      int idx;
      int sx;
      int sy;
      int polygons;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.vertex_x = '0;
      req_chan.vertex_y = '0;
      req_chan.last_vertex = 1'b0;
      polygons = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_vertex(0, 0);
      send_ring();
      add_vertex(32767, -32768); add_vertex(-32768, 32767);
      send_ring();
      add_vertex(-32768, -32768); add_vertex(32767, -32768); add_vertex(32767, 32767);
      send_ring();
      add_vertex(-1, -1); add_vertex(-1, 1); add_vertex(1, 1); add_vertex(1, -1);
      send_ring();
      add_vertex(0, 0); add_vertex(10, 5); add_vertex(0, 10); add_vertex(3, 5);
      send_ring();
      add_vertex(-32768, -32768); add_vertex(0, 0); add_vertex(32767, 32767);
      send_ring();
      add_vertex(5, 5); add_vertex(5, 5); add_vertex(5, 5);
      send_ring();
      add_vertex(32767, 32767); add_vertex(-32768, 32767);
      add_vertex(32767, -32768); add_vertex(-32768, -32768);
      send_ring();
      drain();

      while (beats_sent < 24 + RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) add_vertex(rand_coord(), rand_coord());
         end else if (pick < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
            make_convex(n);
         end else if (pick < 65) begin
            n = $urandom_range(4, 10);
            make_convex(n);
            sx = 0;
            sy = 0;
            for (int i = 0; i < n; i++) begin
               sx += ring_x[i];
               sy += ring_y[i];
            end
            idx = $urandom_range(0, n - 1);
            ring_x[idx] = sx / n;
            ring_y[idx] = sy / n;
         end else if (pick < 85) begin
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++) add_vertex(rand_coord(), rand_coord());
         end else begin
            make_collinear($urandom_range(3, 8));
         end
         send_ring();
         polygons++;
         if (polygons % 60 == 0) drain();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

[filelist.f]
src/cpc_pkg.sv
src/cpc_if.sv
src/cpc_front.sv
src/cpc_cross.sv
src/cpc_judge.sv
src/convex_polygon_check.sv
tb/cpc_checker.sv
tb/testbench.sv
